// File: design/vmcc_pkg.sv
package vmcc_pkg;

	// Kinds of work carried from the front part to the back part.
	localparam logic [1:0] EK_CMD  = 2'd0;
	localparam logic [1:0] EK_WIRE = 2'd1;
	localparam logic [1:0] EK_TICK = 2'd2;
	localparam logic [1:0] EK_BEND = 2'd3;

	// Wire frame types.
	localparam logic [2:0] FK_NONE   = 3'd0;
	localparam logic [2:0] FK_DTMF   = 3'd1;
	localparam logic [2:0] FK_DIAL   = 3'd2;
	localparam logic [2:0] FK_ANSWER = 3'd3;
	localparam logic [2:0] FK_HANGUP = 3'd4;
	localparam logic [2:0] FK_DATA   = 3'd5;
	localparam logic [2:0] FK_END    = 3'd6;

	// Console command and reply words.
	localparam logic [15:0] CMD_WAKE     = 16'hFFFF;
	localparam logic [15:0] CMD_RATE     = 16'hFFFE;
	localparam logic [15:0] CMD_DTMF     = 16'h8A20;
	localparam logic [15:0] CMD_DTMF_MSK = 16'hFFF0;
	localparam logic [15:0] CMD_ANSWER   = 16'h2480;
	localparam logic [15:0] CMD_ORIG     = 16'h2C80;
	localparam logic [15:0] CMD_POLL_LNK = 16'h8C01;
	localparam logic [15:0] CMD_POLL_OFF = 16'h8C00;
	localparam logic [15:0] CMD_DIAL     = 16'h6800;
	localparam logic [15:0] CMD_STATUS   = 16'h8100;
	localparam logic [15:0] CMD_HANGUP   = 16'h9000;
	localparam logic [7:0]  CMD_DATA_HI  = 8'hF0;
	localparam logic [15:0] MSG_AWAKE    = 16'hB800;
	localparam logic [15:0] MSG_NO_DIGIT = 16'hFFFE;
	localparam logic [15:0] MSG_CONN     = 16'h8600;
	localparam logic [15:0] MSG_CONN2    = 16'hA4FC;
	localparam logic [15:0] MSG_IDLE     = 16'h8000;
	localparam logic [15:0] MSG_DROPPED  = 16'hA401;
	localparam logic [15:0] MSG_RING     = 16'hB100;
	localparam logic [15:0] MSG_BURST    = 16'hF301;
	localparam logic [15:0] MSG_DATA     = 16'hF000;

	// Configuration register indexes.
	localparam logic CFG_RING_PERIOD = 1'b0;
	localparam logic CFG_SPEED_CODE  = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       link_up;
	} in_t;

	typedef struct packed {
		logic        to_wire;
		logic [15:0] message_word;
		logic [2:0]  frame_kind;
		logic [7:0]  frame_value;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] word;
		logic        link;
	} entry_t;

	typedef struct packed {
		logic [7:0] ring_period;
		logic [3:0] speed_code;
	} cfg_t;

	function automatic out_t mk_msg(input logic [15:0] w);
		out_t r;
		r = '0;
		r.message_word = w;
		return r;
	endfunction

	function automatic out_t mk_frame(input logic [2:0] k, input logic [7:0] v);
		out_t r;
		r = '0;
		r.to_wire = 1'b1;
		r.frame_kind = k;
		r.frame_value = v;
		return r;
	endfunction

endpackage

// File: design/vmcc_ram.sv
module vmcc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/vmcc_queue.sv
module vmcc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vmcc_pkg::entry_t    push_data,
	input  logic                pop,
	output vmcc_pkg::entry_t    head,
	output logic                empty,
	output logic                full
);

	vmcc_pkg::entry_t slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = slot_q[rp_q];

	// Two-entry ring of work words between the front and back parts.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: design/vmcc_front.sv
module vmcc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  vmcc_pkg::in_t    in_word,
	output logic             push,
	output vmcc_pkg::entry_t push_data
);

	logic       low_held_q;
	logic [7:0] low_byte_q;
	logic       type_held_q;
	logic [7:0] type_byte_q;

	// Pair console bytes into commands and wire bytes into frames; other kinds pass straight through.
	always_comb begin
		push = 1'b0;
		push_data.kind = in_word.mode;
		push_data.link = in_word.link_up;
		push_data.word = {8'd0, in_word.data_byte};
		case (in_word.mode)
			vmcc_pkg::EK_CMD: begin
				push = accept && low_held_q;
				push_data.word = {in_word.data_byte, low_byte_q};
			end
			vmcc_pkg::EK_WIRE: begin
				push = accept && type_held_q;
				push_data.word = {type_byte_q, in_word.data_byte};
			end
			default: begin
				push = accept;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && in_word.mode == vmcc_pkg::EK_CMD && !low_held_q) begin
			low_byte_q <= in_word.data_byte;
		end
		if (accept && in_word.mode == vmcc_pkg::EK_WIRE && !type_held_q) begin
			type_byte_q <= in_word.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_held_q  <= 1'b0;
			type_held_q <= 1'b0;
		end else if (accept) begin
			if (in_word.mode == vmcc_pkg::EK_CMD) begin
				low_held_q <= ~low_held_q;
			end
			if (in_word.mode == vmcc_pkg::EK_WIRE) begin
				type_held_q <= ~type_held_q;
			end
		end
	end

endmodule

// File: design/vmcc_back.sv
module vmcc_back #(
	parameter int HEARD_DEPTH = 32,
	parameter int PENDING_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vmcc_pkg::cfg_t   cfg,
	input  vmcc_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output vmcc_pkg::out_t   out_data
);

	localparam int HW  = (HEARD_DEPTH > 1) ? $clog2(HEARD_DEPTH) : 1;
	localparam int HCW = $clog2(HEARD_DEPTH + 1);
	localparam int PW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PCW = $clog2(PENDING_DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EMIT = 2'd1;
	localparam logic [1:0] S_FRD  = 2'd2;
	localparam logic [1:0] S_FOUT = 2'd3;

	logic [1:0] state_q, state_d;
	logic awake_q, awake_d, answer_q, answer_d, conn_q, conn_d;
	logic dialed_q, dialed_d, dds_q, dds_d, rp_q, rp_d, burst_q, burst_d;
	logic [7:0] cd_q, cd_d;
	logic [HW-1:0] head_q, head_d;
	logic [HCW-1:0] hc_q, hc_d;
	logic [PCW-1:0] pc_q, pc_d;
	logic [PCW-1:0] fn_q, fn_d, fi_q, fi_d;
	vmcc_pkg::out_t r0_q, r0_d, r1_q, r1_d, out_q, out_d;
	logic r0v_q, r0v_d, r1v_q, r1v_d, r0h_q, r0h_d, r1h_q, r1h_d;
	logic out_valid_q, out_valid_d;

	logic          h_we, h_re, p_we, p_re;
	logic [HW-1:0] h_waddr;
	logic [HW:0]   h_tail;
	logic [PW-1:0] p_raddr;
	logic [3:0]    h_rdata, p_rdata;
	logic          out_free;
	logic [15:0]   w;

	assign w = head.word;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign p_raddr = fi_q[PW-1:0];

	// Write slot of the heard queue, wrapped once at the depth.
	always_comb begin
		h_tail = {1'b0, head_q} + {1'b0, hc_q[HW-1:0]};
		if (h_tail >= (HW+1)'(HEARD_DEPTH)) begin
			h_tail = h_tail - (HW+1)'(HEARD_DEPTH);
		end
		h_waddr = h_tail[HW-1:0];
	end

	vmcc_ram #(.WIDTH(4), .DEPTH(HEARD_DEPTH), .AW(HW)) u_heard (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(w[3:0]),
		.re(h_re), .raddr(head_q), .rdata(h_rdata)
	);

	vmcc_ram #(.WIDTH(4), .DEPTH(PENDING_DEPTH), .AW(PW)) u_pending (
		.clk(clk), .we(p_we), .waddr(pc_q[PW-1:0]), .wdata(w[3:0]),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata)
	);

	// Command execution: one work word is evaluated, then its results are sent in order.
	always_comb begin
		state_d = state_q;
		awake_d = awake_q; answer_d = answer_q; conn_d = conn_q;
		dialed_d = dialed_q; dds_d = dds_q; rp_d = rp_q; burst_d = burst_q;
		cd_d = cd_q; head_d = head_q; hc_d = hc_q; pc_d = pc_q;
		fn_d = fn_q; fi_d = fi_q;
		r0_d = r0_q; r1_d = r1_q;
		r0v_d = r0v_q; r1v_d = r1v_q; r0h_d = r0h_q; r1h_d = r1h_q;
		out_d = out_q;
		out_valid_d = out_valid_q && out_stall;
		pop = 1'b0;
		h_we = 1'b0; h_re = 1'b0; p_we = 1'b0; p_re = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					state_d = S_EMIT;
					r0v_d = 1'b0; r1v_d = 1'b0; r0h_d = 1'b0; r1h_d = 1'b0;
					fn_d = '0; fi_d = '0;
					case (head.kind)
						vmcc_pkg::EK_CMD: begin
							if (w == vmcc_pkg::CMD_WAKE || w == vmcc_pkg::CMD_HANGUP) begin
								// Wake and hang-up both drop any call.
								if (w == vmcc_pkg::CMD_WAKE) begin
									awake_d = 1'b1;
									r1_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_AWAKE);
								end else begin
									r1_d = vmcc_pkg::mk_msg(w);
								end
								r1v_d = 1'b1;
								r0_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_HANGUP, 8'd0);
								r0v_d = (conn_q || dialed_q) && head.link;
								conn_d = 1'b0; dialed_d = 1'b0; dds_d = 1'b0;
								rp_d = 1'b0; burst_d = 1'b0; pc_d = '0;
								head_d = '0; hc_d = '0;
							end else if (w == vmcc_pkg::CMD_RATE) begin
								// Rate switch has no effect.
							end else if ((w & vmcc_pkg::CMD_DTMF_MSK) == vmcc_pkg::CMD_DTMF) begin
								r0_d = vmcc_pkg::mk_msg(w);
								r0v_d = 1'b1;
								r1_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_DTMF, {4'd0, w[3:0]});
								if (conn_q) begin
									r1v_d = head.link;
								end else if (answer_q) begin
									if (pc_q < PCW'(PENDING_DEPTH)) begin
										p_we = 1'b1;
										pc_d = pc_q + 1'b1;
									end
								end else begin
									dds_d = 1'b1;
								end
							end else if (w == vmcc_pkg::CMD_ANSWER) begin
								answer_d = 1'b1;
								r0_d = vmcc_pkg::mk_msg(w);
								r0v_d = 1'b1;
								r1_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_ANSWER, 8'd0);
								if (rp_q && !conn_q) begin
									r1v_d = head.link;
									conn_d = 1'b1; rp_d = 1'b0; pc_d = '0;
									fn_d = head.link ? pc_q : '0;
								end
							end else if (w == vmcc_pkg::CMD_ORIG) begin
								answer_d = 1'b0;
								r0_d = vmcc_pkg::mk_msg(w);
								r0v_d = 1'b1;
							end else if (w == vmcc_pkg::CMD_POLL_LNK) begin
								r0_d = vmcc_pkg::mk_msg(head.link ? vmcc_pkg::CMD_POLL_LNK
									: vmcc_pkg::CMD_POLL_OFF);
								r0v_d = 1'b1;
							end else if (w == vmcc_pkg::CMD_POLL_OFF) begin
								r0_d = vmcc_pkg::mk_msg(vmcc_pkg::CMD_POLL_OFF);
								r0v_d = 1'b1;
							end else if (w == vmcc_pkg::CMD_DIAL) begin
								// Dial goes out once a digit was keyed; then one heard digit is read.
								r0_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_DIAL, 8'd0);
								if (!dialed_q && !answer_q && dds_q) begin
									dds_d = 1'b0; dialed_d = 1'b1;
									r0v_d = head.link;
								end
								r1v_d = 1'b1;
								if (hc_q != '0) begin
									h_re = 1'b1;
									r1h_d = 1'b1;
									r1_d = vmcc_pkg::mk_msg(vmcc_pkg::CMD_DIAL);
									head_d = (head_q == HW'(HEARD_DEPTH - 1)) ? '0 : head_q + 1'b1;
									hc_d = hc_q - 1'b1;
								end else begin
									r1_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_NO_DIGIT);
								end
							end else if (w == vmcc_pkg::CMD_STATUS) begin
								r0v_d = 1'b1;
								if (conn_q) begin
									r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_CONN
										| {8'd0, cfg.speed_code, 4'd0});
									r1_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_CONN2);
									r1v_d = 1'b1;
								end else begin
									r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_IDLE);
								end
							end else if (w[15:8] == vmcc_pkg::CMD_DATA_HI) begin
								r0_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_DATA, w[7:0]);
								if (conn_q) begin
									r0v_d = head.link;
									burst_d = 1'b1;
								end
							end else begin
								// Unknown commands are echoed.
								r0_d = vmcc_pkg::mk_msg(w);
								r0v_d = 1'b1;
							end
						end
						vmcc_pkg::EK_WIRE: begin
							case (w[15:8])
								8'(vmcc_pkg::FK_DTMF): begin
									if (hc_q < HCW'(HEARD_DEPTH)) begin
										h_we = 1'b1;
										hc_d = hc_q + 1'b1;
									end
								end
								8'(vmcc_pkg::FK_DIAL): begin
									r0_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_ANSWER, 8'd0);
									if (answer_q && !conn_q) begin
										r0v_d = head.link;
										conn_d = 1'b1; rp_d = 1'b0; pc_d = '0;
										fn_d = head.link ? pc_q : '0;
									end else if (!conn_q) begin
										rp_d = 1'b1;
										cd_d = 8'd0;
									end
								end
								8'(vmcc_pkg::FK_ANSWER): begin
									conn_d = 1'b1; rp_d = 1'b0; pc_d = '0;
									fn_d = head.link ? pc_q : '0;
								end
								8'(vmcc_pkg::FK_HANGUP): begin
									r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_DROPPED);
									r0v_d = conn_q && awake_q;
									conn_d = 1'b0; dialed_d = 1'b0; rp_d = 1'b0;
									head_d = '0; hc_d = '0;
								end
								8'(vmcc_pkg::FK_DATA): begin
									r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_DATA | {8'd0, w[7:0]});
									r0v_d = 1'b1;
								end
								8'(vmcc_pkg::FK_END): begin
									r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_BURST);
									r0v_d = 1'b1;
								end
								default: begin
								end
							endcase
						end
						vmcc_pkg::EK_TICK: begin
							// Ring pacing while a call waits to be answered.
							r0_d = vmcc_pkg::mk_msg(vmcc_pkg::MSG_RING);
							if (rp_q && !conn_q && awake_q) begin
								if (cd_q == 8'd0) begin
									r0v_d = 1'b1;
									cd_d = cfg.ring_period;
								end else begin
									cd_d = cd_q - 8'd1;
								end
							end
						end
						default: begin
							r0_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_END, 8'd0);
							if (burst_q) begin
								burst_d = 1'b0;
								r0v_d = head.link;
							end
						end
					endcase
				end
			end
			S_EMIT: begin
				// Send the fixed results first, then any pending digit flush.
				if (r0v_q) begin
					if (out_free) begin
						out_d = r0_q;
						if (r0h_q) begin
							out_d.message_word = vmcc_pkg::CMD_DIAL | {12'd0, h_rdata};
						end
						out_d.last = !r1v_q && (fn_q == '0);
						out_valid_d = 1'b1;
						r0v_d = 1'b0;
					end
				end else if (r1v_q) begin
					if (out_free) begin
						out_d = r1_q;
						if (r1h_q) begin
							out_d.message_word = vmcc_pkg::CMD_DIAL | {12'd0, h_rdata};
						end
						out_d.last = (fn_q == '0);
						out_valid_d = 1'b1;
						r1v_d = 1'b0;
					end
				end else if (fn_q != '0) begin
					state_d = S_FRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FRD: begin
				p_re = 1'b1;
				state_d = S_FOUT;
			end
			default: begin
				if (out_free) begin
					out_d = vmcc_pkg::mk_frame(vmcc_pkg::FK_DTMF, {4'd0, p_rdata});
					out_d.last = (fi_q + 1'b1 == fn_q);
					out_valid_d = 1'b1;
					fi_d = fi_q + 1'b1;
					state_d = (fi_q + 1'b1 == fn_q) ? S_IDLE : S_FRD;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		r0_q <= r0_d;
		r1_q <= r1_d;
		out_q <= out_d;
		fn_q <= fn_d;
		fi_q <= fi_d;
		r0h_q <= r0h_d;
		r1h_q <= r1h_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			awake_q <= 1'b0; answer_q <= 1'b0; conn_q <= 1'b0;
			dialed_q <= 1'b0; dds_q <= 1'b0; rp_q <= 1'b0; burst_q <= 1'b0;
			cd_q <= 8'd0; head_q <= '0; hc_q <= '0; pc_q <= '0;
			r0v_q <= 1'b0; r1v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			awake_q <= awake_d; answer_q <= answer_d; conn_q <= conn_d;
			dialed_q <= dialed_d; dds_q <= dds_d; rp_q <= rp_d; burst_q <= burst_d;
			cd_q <= cd_d; head_q <= head_d; hc_q <= hc_d; pc_q <= pc_d;
			r0v_q <= r0v_d; r1v_q <= r1v_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// File: design/voice_modem_call_controller.sv
// Modem call controller. Console bytes pair into commands (low byte first) and wire bytes
// pair into frames in the front part, which passes each finished word through a two-entry
// queue; the back part executes one word at a time and sends its results through an output
// register, so input is taken while results wait. A word is evaluated in the idle state,
// its results are then sent one at a time, holding while the output stalls, and the back
// part then returns to idle; each digit of a pending-digit flush is first read from the
// digit memory, whose read is registered, and then sent, so the worst word is an answer with
// sixteen pending digits. The first byte of a pair is only held in the front part.
module voice_modem_call_controller #(
	parameter int HEARD_DEPTH = 32,
	parameter int PENDING_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  vmcc_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output vmcc_pkg::out_t   out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data
);

	vmcc_pkg::cfg_t   cfg_q;
	vmcc_pkg::entry_t push_data;
	vmcc_pkg::entry_t head;
	logic push, pop, empty, full;

	assign in_stall = full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_period <= 8'd60;
			cfg_q.speed_code <= 4'd13;
		end else if (cfg_we) begin
			case (cfg_index)
				vmcc_pkg::CFG_RING_PERIOD: cfg_q.ring_period <= cfg_data;
				vmcc_pkg::CFG_SPEED_CODE: cfg_q.speed_code <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	vmcc_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(in_valid && !in_stall),
		.in_word(in_data), .push(push), .push_data(push_data)
	);

	vmcc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .empty(empty), .full(full)
	);

	vmcc_back #(.HEARD_DEPTH(HEARD_DEPTH), .PENDING_DEPTH(PENDING_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .head(head), .empty(empty),
		.pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
